### sv/ajfm_pkg.sv
// Shared types and constants for the audio jitter FIFO mixer.
package ajfm_pkg;

    // Ring geometry (CAPACITY must be a power of two)
    localparam int CAPACITY    = 4096;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int FILL_W      = $clog2(CAPACITY + 1);
    localparam int SAMPLE_BITS = 24;

    // Field widths fixed by the interface
    localparam int COUNT_W = 13;
    localparam int MODE_W  = 2;
    localparam int EVT_W   = 32;

    // Remaining-element counter holds either a count or a fill level
    localparam int REM_W  = (FILL_W > COUNT_W) ? FILL_W : COUNT_W;
    localparam int WIDE_W = REM_W + 1;

    // Element modes
    localparam logic [MODE_W-1:0] MODE_PUSH    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CONSUME = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 2'd2;

    // Input item
    typedef struct packed {
        logic [MODE_W-1:0]             mode;
        logic                          first;
        logic [COUNT_W-1:0]            count;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic signed [SAMPLE_BITS-1:0] mix_in;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mix_out;
        logic                          accepted;
        logic                          ready_res;
        logic [COUNT_W-1:0]            level;
        logic                          starved;
        logic [EVT_W-1:0]              overflow_events;
        logic [EVT_W-1:0]              underrun_events;
    } t_out_item;

    // Sample RAM command from the control unit
    typedef struct packed {
        logic                   we;
        logic [ADDR_W-1:0]      waddr;
        logic [SAMPLE_BITS-1:0] wdata;
        logic                   re;
        logic [ADDR_W-1:0]      raddr;
    } t_ram_cmd;

    // Per-element results handed to the mix stage
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mix_in;
        logic                          play;
        logic                          accepted;
        logic                          ready_res;
        logic [COUNT_W-1:0]            level;
        logic                          starved;
        logic [EVT_W-1:0]              overflow_events;
        logic [EVT_W-1:0]              underrun_events;
    } t_stage;

endpackage

### sv/audio_jitter_fifo_mixer.sv
// Top level of the audio jitter FIFO mixer.
// Audio jitter FIFO with mixing and underrun recovery, one element per transfer. Push elements
// store samples into a 4096-entry ring only when the whole call fits; consume elements add
// buffered samples into mix_in with Q1.23 saturation; query elements report whether the fill
// reaches count. Decisions for a call are taken on its first element. One element is accepted
// every cycle while the output is not stalled. Decode results and the sample RAM's registered read
// sit side by side in the decode stage; the mix result goes into the output register, which lets
// the next element in while a result waits. The sample RAM needs no clearing pass; only entries
// inside the fill are ever read. recover_threshold is written through i_cfg_we.
module audio_jitter_fifo_mixer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ajfm_pkg::COUNT_W-1:0] i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  ajfm_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output ajfm_pkg::t_out_item          o_out_data
);

    logic                             accept;
    ajfm_pkg::t_ram_cmd               ram_cmd;
    ajfm_pkg::t_stage                 info;
    logic [ajfm_pkg::SAMPLE_BITS-1:0] rdata;

    // Control and ring state
    ajfm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_item      (i_in_data),
        .o_ram       (ram_cmd),
        .o_info      (info)
    );

    // Sample store
    ajfm_ram #(
        .WIDTH (ajfm_pkg::SAMPLE_BITS),
        .DEPTH (ajfm_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_cmd.we),
        .i_waddr (ram_cmd.waddr),
        .i_wdata (ram_cmd.wdata),
        .i_re    (ram_cmd.re),
        .i_raddr (ram_cmd.raddr),
        .o_rdata (rdata)
    );

    // Mix and output stage
    ajfm_mix u_mix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_accept    (accept),
        .i_info      (info),
        .i_rdata     (rdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### sv/ajfm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ajfm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/ajfm_ctrl.sv
// FIFO control: ring pointers, call decisions, event counters and threshold register.
module ajfm_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ajfm_pkg::COUNT_W-1:0] i_cfg_wdata,
    input  logic                       i_accept,
    input  ajfm_pkg::t_in_item         i_item,
    output ajfm_pkg::t_ram_cmd         o_ram,
    output ajfm_pkg::t_stage           o_info
);

    logic [ajfm_pkg::ADDR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [ajfm_pkg::FILL_W-1:0]  r_fill, n_fill;
    logic                         r_exh, n_exh;
    logic [ajfm_pkg::EVT_W-1:0]   r_ovf, n_ovf;
    logic [ajfm_pkg::EVT_W-1:0]   r_und, n_und;
    logic                         r_call_acc, n_call_acc;
    logic [ajfm_pkg::REM_W-1:0]   r_rem, n_rem;
    logic [ajfm_pkg::MODE_W-1:0]  r_kind, n_kind;
    logic [ajfm_pkg::COUNT_W-1:0] r_thr;

    logic [ajfm_pkg::WIDE_W-1:0]  fill_w, cnt_w, thr_w;
    logic [ajfm_pkg::FILL_W-1:0]  wr_sum;
    logic                         we, re, play, acc, rdy;

    assign fill_w = ajfm_pkg::WIDE_W'(r_fill);
    assign cnt_w  = ajfm_pkg::WIDE_W'(i_item.count);
    assign thr_w  = ajfm_pkg::WIDE_W'(r_thr);
    assign wr_sum = ajfm_pkg::FILL_W'(r_rd_ptr) + r_fill;

    // Element decode and next state
    always_comb begin
        n_rd_ptr   = r_rd_ptr;
        n_fill     = r_fill;
        n_exh      = r_exh;
        n_ovf      = r_ovf;
        n_und      = r_und;
        n_call_acc = r_call_acc;
        n_rem      = r_rem;
        n_kind     = r_kind;
        we         = 1'b0;
        re         = 1'b0;
        play       = 1'b0;
        acc        = 1'b0;
        rdy        = 1'b0;
        case (i_item.mode)
            ajfm_pkg::MODE_PUSH: begin
                // whole block fits or the call is rejected
                if (i_item.first) begin
                    n_kind = ajfm_pkg::MODE_PUSH;
                    if (fill_w + cnt_w > ajfm_pkg::WIDE_W'(ajfm_pkg::CAPACITY)) begin
                        n_ovf      = r_ovf + 1'b1;
                        n_call_acc = 1'b0;
                        n_rem      = '0;
                    end else begin
                        n_call_acc = 1'b1;
                        n_rem      = ajfm_pkg::REM_W'(i_item.count);
                    end
                end
                if (n_kind == ajfm_pkg::MODE_PUSH) begin
                    acc = n_call_acc;
                    if (n_call_acc && n_rem != '0 &&
                        fill_w < ajfm_pkg::WIDE_W'(ajfm_pkg::CAPACITY)) begin
                        we     = 1'b1;
                        n_fill = r_fill + 1'b1;
                        n_rem  = n_rem - 1'b1;
                    end
                end
            end
            ajfm_pkg::MODE_CONSUME: begin
                // underrun handling and recovery decided on the first element
                if (i_item.first) begin
                    n_kind     = ajfm_pkg::MODE_CONSUME;
                    n_call_acc = 1'b0;
                    if (r_exh && fill_w < thr_w) begin
                        n_und = r_und + 1'b1;
                        n_rem = '0;
                    end else begin
                        n_exh = 1'b0;
                        if (fill_w < cnt_w) begin
                            n_rem = ajfm_pkg::REM_W'(r_fill);
                            n_exh = 1'b1;
                            n_und = r_und + 1'b1;
                        end else begin
                            n_rem = ajfm_pkg::REM_W'(i_item.count);
                        end
                    end
                end
                if (n_kind == ajfm_pkg::MODE_CONSUME && n_rem != '0 && r_fill != '0) begin
                    re       = 1'b1;
                    play     = 1'b1;
                    n_rd_ptr = r_rd_ptr + 1'b1;
                    n_fill   = r_fill - 1'b1;
                    n_rem    = n_rem - 1'b1;
                end
            end
            ajfm_pkg::MODE_QUERY: begin
                if (i_item.first) begin
                    n_kind     = ajfm_pkg::MODE_QUERY;
                    n_call_acc = 1'b0;
                    n_rem      = '0;
                end
                rdy = (fill_w >= cnt_w);
            end
            default: begin
                // unused mode: element ignored
            end
        endcase
    end

    // State registers, updated once per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr   <= '0;
            r_fill     <= '0;
            r_exh      <= 1'b0;
            r_ovf      <= '0;
            r_und      <= '0;
            r_call_acc <= 1'b0;
            r_rem      <= '0;
            r_kind     <= ajfm_pkg::MODE_PUSH;
        end else if (i_accept) begin
            r_rd_ptr   <= n_rd_ptr;
            r_fill     <= n_fill;
            r_exh      <= n_exh;
            r_ovf      <= n_ovf;
            r_und      <= n_und;
            r_call_acc <= n_call_acc;
            r_rem      <= n_rem;
            r_kind     <= n_kind;
        end
    end

    // Recovery threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    // RAM command
    assign o_ram.we    = i_accept && we;
    assign o_ram.waddr = wr_sum[ajfm_pkg::ADDR_W-1:0];
    assign o_ram.wdata = i_item.sample;
    assign o_ram.re    = i_accept && re;
    assign o_ram.raddr = r_rd_ptr;

    // Results known at decode time
    assign o_info.mix_in          = i_item.mix_in;
    assign o_info.play            = play;
    assign o_info.accepted        = acc;
    assign o_info.ready_res       = rdy;
    assign o_info.level           = ajfm_pkg::COUNT_W'(n_fill);
    assign o_info.starved         = n_exh;
    assign o_info.overflow_events = n_ovf;
    assign o_info.underrun_events = n_und;

endmodule

### sv/ajfm_mix.sv
// Mix stage: holds decoded element while RAM data returns, then saturating add into output register.
module ajfm_mix (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    output logic                              o_accept,
    input  ajfm_pkg::t_stage                  i_info,
    input  logic [ajfm_pkg::SAMPLE_BITS-1:0]  i_rdata,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output ajfm_pkg::t_out_item               o_out_data
);

    logic                        r_s1_valid;
    ajfm_pkg::t_stage            r_s1;
    logic                        r_out_valid;
    ajfm_pkg::t_out_item         r_out;

    logic                        adv;
    logic [ajfm_pkg::SAMPLE_BITS:0] sum;
    logic [ajfm_pkg::SAMPLE_BITS-1:0] sat;
    ajfm_pkg::t_out_item         n_out;

    // Handshake: output register frees the stage, stage frees the input
    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || adv;
    assign o_accept   = i_in_valid && o_in_ready;

    // Saturating Q1.23 add of the played sample
    assign sum = {r_s1.mix_in[ajfm_pkg::SAMPLE_BITS-1], r_s1.mix_in}
               + {i_rdata[ajfm_pkg::SAMPLE_BITS-1], i_rdata};

    always_comb begin
        if (sum[ajfm_pkg::SAMPLE_BITS] != sum[ajfm_pkg::SAMPLE_BITS-1]) begin
            sat = {sum[ajfm_pkg::SAMPLE_BITS], {(ajfm_pkg::SAMPLE_BITS-1){~sum[ajfm_pkg::SAMPLE_BITS]}}};
        end else begin
            sat = sum[ajfm_pkg::SAMPLE_BITS-1:0];
        end
    end

    always_comb begin
        n_out.mix_out         = r_s1.play ? sat : r_s1.mix_in;
        n_out.accepted        = r_s1.accepted;
        n_out.ready_res       = r_s1.ready_res;
        n_out.level           = r_s1.level;
        n_out.starved         = r_s1.starved;
        n_out.overflow_events = r_s1.overflow_events;
        n_out.underrun_events = r_s1.underrun_events;
    end

    // Decode stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_accept) begin
            r_s1_valid <= 1'b1;
        end else if (adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_accept) begin
            r_s1 <= i_info;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### sv/ajfm_chk.sv
// Port-level checker for the audio jitter FIFO mixer, bound to the top level.
module ajfm_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input ajfm_pkg::t_out_item o_out_data
);

    // Reset empties the output register
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Fill never exceeds the ring capacity
    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.level <= ajfm_pkg::COUNT_W'(ajfm_pkg::CAPACITY))
        else $error("level beyond capacity");

    // Push acceptance and query readiness come from different modes
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.accepted && o_out_data.ready_res))
        else $error("accepted and ready_res both set");

endmodule

bind audio_jitter_fifo_mixer ajfm_chk u_ajfm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

### dv/audio_jitter_fifo_mixer_tb.sv
// Self-checking testbench for the audio jitter FIFO mixer.
module audio_jitter_fifo_mixer_tb;
    import ajfm_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int SAT_MAX   = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int SAT_MIN   = -(1 << (SAMPLE_BITS - 1));
    localparam int COUNT_MAX = (1 << COUNT_W) - 1;
    localparam logic signed [SAMPLE_BITS-1:0] PEAK_POS = SAMPLE_BITS'(SAT_MAX);
    localparam logic signed [SAMPLE_BITS-1:0] PEAK_NEG = SAMPLE_BITS'(SAT_MIN);

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [COUNT_W-1:0] i_cfg_wdata = '0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    t_in_item           i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out_item          o_out_data;

    audio_jitter_fifo_mixer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 8-unit clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Mirror of the jitter buffer state
    logic signed [SAMPLE_BITS-1:0] ring_mem [CAPACITY];
    logic [ADDR_W-1:0]  rd_ptr;
    logic [FILL_W-1:0]  fill_lvl;
    logic               starved_st;
    logic [EVT_W-1:0]   ovf_cnt;
    logic [EVT_W-1:0]   udr_cnt;
    logic               call_ok;
    logic [REM_W-1:0]   play_left;
    logic [MODE_W-1:0]  call_mode;
    logic [COUNT_W-1:0] thresh;

    t_out_item expected_mix_q [$];
    int        n_errors   = 0;
    int        idle_pct   = 0;
    int        stall_left = 0;
    int        n_push     = 0;
    int        n_consume  = 0;
    int        n_query    = 0;
    int        n_counted  = 0;

    function automatic void clear_buffer_model();
        foreach (ring_mem[i]) ring_mem[i] = '0;
        rd_ptr     = '0;
        fill_lvl   = '0;
        starved_st = 1'b0;
        ovf_cnt    = '0;
        udr_cnt    = '0;
        call_ok    = 1'b0;
        play_left  = '0;
        call_mode  = MODE_PUSH;
        thresh     = '0;
    endfunction

    // Advance the mirror by one element and return its expected result
    function automatic t_out_item predict_element(t_in_item it);
        t_out_item r;
        int        wr;
        int        sum;
        r         = '0;
        r.mix_out = it.mix_in;
        case (it.mode)
            MODE_PUSH: begin
                if (it.first) begin
                    call_mode = MODE_PUSH;
                    if (int'(fill_lvl) + int'(it.count) > CAPACITY) begin
                        ovf_cnt++;
                        call_ok   = 1'b0;
                        play_left = '0;
                    end else begin
                        call_ok   = 1'b1;
                        play_left = it.count;
                    end
                end
                if (call_mode == MODE_PUSH) begin
                    r.accepted = call_ok;
                    if (call_ok && play_left != 0 && fill_lvl < CAPACITY) begin
                        wr = (int'(rd_ptr) + int'(fill_lvl)) % CAPACITY;
                        ring_mem[wr] = it.sample;
                        fill_lvl++;
                        play_left--;
                    end
                end
            end
            MODE_CONSUME: begin
                if (it.first) begin
                    call_mode = MODE_CONSUME;
                    call_ok   = 1'b0;
                    if (starved_st && fill_lvl < thresh) begin
                        udr_cnt++;
                        play_left = '0;
                    end else begin
                        starved_st = 1'b0;
                        if (fill_lvl < it.count) begin
                            play_left  = fill_lvl;
                            starved_st = 1'b1;
                            udr_cnt++;
                        end else begin
                            play_left = it.count;
                        end
                    end
                end
                if (call_mode == MODE_CONSUME && play_left != 0 && fill_lvl != 0) begin
                    sum = int'(it.mix_in) + int'(ring_mem[rd_ptr]);
                    if (sum > SAT_MAX) sum = SAT_MAX;
                    if (sum < SAT_MIN) sum = SAT_MIN;
                    r.mix_out = sum[SAMPLE_BITS-1:0];
                    rd_ptr++;
                    fill_lvl--;
                    play_left--;
                end
            end
            MODE_QUERY: begin
                if (it.first) begin
                    call_mode = MODE_QUERY;
                    call_ok   = 1'b0;
                    play_left = '0;
                end
                r.ready_res = (fill_lvl >= it.count);
            end
            default: ;
        endcase
        r.level           = fill_lvl;
        r.starved         = starved_st;
        r.overflow_events = ovf_cnt;
        r.underrun_events = udr_cnt;
        return r;
    endfunction

    // Mostly random samples, with full-scale values now and then
    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return PEAK_POS;
            1:       return PEAK_NEG;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(0, 16);
        if (r < 95) return $urandom_range(17, 64);
        return $urandom_range(0, COUNT_MAX);
    endfunction

    // Drive one element; returns at the falling edge after its transfer
    task automatic send_item(logic [MODE_W-1:0] m, logic f, int n,
                             logic signed [SAMPLE_BITS-1:0] s,
                             logic signed [SAMPLE_BITS-1:0] x);
        t_in_item it;
        it.mode   = m;
        it.first  = f;
        it.count  = n[COUNT_W-1:0];
        it.sample = s;
        it.mix_in = x;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_mix_q.push_back(predict_element(it));
        case (m)
            MODE_PUSH:    n_push++;
            MODE_CONSUME: n_consume++;
            MODE_QUERY:   n_query++;
            default: ;
        endcase
        if (m != MODE_UNUSED) n_counted++;
        @(negedge i_clk);
    endtask

    // A call: one first element followed by n_elems-1 more, random payload
    task automatic send_call(logic [MODE_W-1:0] m, int n, int n_elems);
        for (int i = 0; i < n_elems; i++) begin
            send_item(m, i == 0, n, rand_sample(), rand_sample());
        end
    endtask

    // Threshold write once everything in flight has come out
    task automatic write_threshold(int v);
        i_in_valid <= 1'b0;
        while (expected_mix_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v[COUNT_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        thresh   = v[COUNT_W-1:0];
    endtask

    task automatic check_field(string name, logic signed [63:0] exp_v,
                               logic signed [63:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_mix_q.size() == 0) begin
                $error("result transfer with no element pending, level %0d",
                       o_out_data.level);
                n_errors++;
            end else begin
                want = expected_mix_q.pop_front();
                check_field("mix_out", 64'(want.mix_out), 64'(o_out_data.mix_out));
                check_field("accepted", 64'(want.accepted), 64'(o_out_data.accepted));
                check_field("ready_res", 64'(want.ready_res), 64'(o_out_data.ready_res));
                check_field("level", 64'(want.level), 64'(o_out_data.level));
                check_field("starved", 64'(want.starved), 64'(o_out_data.starved));
                check_field("overflow_events", 64'(want.overflow_events),
                            64'(o_out_data.overflow_events));
                check_field("underrun_events", 64'(want.underrun_events),
                            64'(o_out_data.underrun_events));
            end
        end
    end

    // Output back-pressure in random bursts, started with a chance of idle_pct percent
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            stall_left = $urandom_range(0, 3);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Hand-picked elements: field extremes, saturation, stray and foreign elements
    task automatic test_directed_cases();
        idle_pct = 25;
        send_item(MODE_QUERY, 1'b1, 0, rand_sample(), rand_sample());
        send_item(MODE_QUERY, 1'b1, COUNT_MAX, rand_sample(), rand_sample());
        send_item(MODE_UNUSED, 1'b1, COUNT_MAX, PEAK_POS, PEAK_NEG);
        send_item(MODE_CONSUME, 1'b1, 0, rand_sample(), rand_sample());
        // underrun on an empty buffer
        send_item(MODE_CONSUME, 1'b1, 2, rand_sample(), rand_sample());
        send_item(MODE_CONSUME, 1'b0, 2, rand_sample(), rand_sample());
        // zero-length push, then a block of three plus one stray element
        send_item(MODE_PUSH, 1'b1, 0, rand_sample(), rand_sample());
        send_item(MODE_PUSH, 1'b1, 3, PEAK_POS, rand_sample());
        send_item(MODE_PUSH, 1'b0, 3, PEAK_NEG, rand_sample());
        send_item(MODE_PUSH, 1'b0, 3, 24'sd1, rand_sample());
        send_item(MODE_PUSH, 1'b0, 3, 24'sd5, rand_sample());
        // foreign element inside a push call
        send_item(MODE_CONSUME, 1'b0, 3, rand_sample(), PEAK_POS);
        // oversized push is rejected, its tail stores nothing
        send_item(MODE_PUSH, 1'b1, COUNT_MAX, rand_sample(), rand_sample());
        send_item(MODE_PUSH, 1'b0, COUNT_MAX, rand_sample(), rand_sample());
        // recovery, saturation both ways, then pass-through past the count
        send_item(MODE_CONSUME, 1'b1, 2, rand_sample(), PEAK_POS);
        send_item(MODE_CONSUME, 1'b0, 2, rand_sample(), PEAK_NEG);
        send_item(MODE_CONSUME, 1'b0, 2, rand_sample(), rand_sample());

        // held back until the fill reaches two
        write_threshold(2);
        send_item(MODE_CONSUME, 1'b1, 4, rand_sample(), rand_sample());
        send_item(MODE_CONSUME, 1'b0, 4, rand_sample(), rand_sample());
        send_item(MODE_PUSH, 1'b1, 1, rand_sample(), rand_sample());
        send_item(MODE_CONSUME, 1'b1, 1, rand_sample(), rand_sample());
        send_call(MODE_PUSH, 2, 2);
        send_item(MODE_QUERY, 1'b1, 3, rand_sample(), rand_sample());
        send_item(MODE_CONSUME, 1'b1, 1, rand_sample(), rand_sample());
        // a query cuts a push call short
        send_item(MODE_PUSH, 1'b1, 2, rand_sample(), rand_sample());
        send_item(MODE_QUERY, 1'b1, 1, rand_sample(), rand_sample());
        send_item(MODE_PUSH, 1'b0, 2, rand_sample(), rand_sample());
        write_threshold(0);
    endtask

    // Push decisions right at the capacity boundary, then an oversized drain
    task automatic test_capacity_bounds();
        int room;
        idle_pct = 15;
        // a block that exactly fills the free space is accepted
        room = CAPACITY - int'(fill_lvl);
        send_call(MODE_PUSH, room, 4);
        // one sample more than the free space is rejected
        room = CAPACITY - int'(fill_lvl);
        send_call(MODE_PUSH, room + 1, 2);
        send_call(MODE_PUSH, room, 1);
        send_call(MODE_QUERY, CAPACITY, 1);
        send_call(MODE_QUERY, int'(fill_lvl), 1);
        send_call(MODE_QUERY, int'(fill_lvl) + 1, 1);
        // ask for more than is held: drain, underrun, pass-through
        send_call(MODE_CONSUME, int'(fill_lvl) + 1, int'(fill_lvl) + 2);
        send_call(MODE_CONSUME, 1, 1);
    endtask

    // Mostly well-formed calls with random content, plus stray and broken ones
    task automatic random_calls(int n_items, bit steady);
        int target;
        int kind;
        int n;
        int elems;
        target = n_counted + n_items;
        while (n_counted < target) begin
            if (!steady && $urandom_range(7) == 0) begin
                case ($urandom_range(3))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    2:       idle_pct = 30;
                    default: idle_pct = 60;
                endcase
            end
            kind = $urandom_range(99);
            if (kind < 40) begin
                n     = pick_len();
                elems = (n <= 64) ? n : $urandom_range(1, 6);
                if ($urandom_range(9) == 0) elems++;
                if (elems == 0) elems = 1;
                send_call(MODE_PUSH, n, elems);
            end else if (kind < 78) begin
                n = pick_len();
                if ($urandom_range(3) == 0) n = int'(fill_lvl) + $urandom_range(0, 1);
                elems = (n <= 64) ? n : $urandom_range(1, 6);
                if ($urandom_range(9) == 0) elems++;
                if (elems == 0) elems = 1;
                send_call(MODE_CONSUME, n, elems);
            end else if (kind < 88) begin
                if ($urandom_range(1) == 0) begin
                    n = int'(fill_lvl) + $urandom_range(0, 2) - 1;
                    if (n < 0) n = 0;
                end else begin
                    n = $urandom_range(0, COUNT_MAX);
                end
                send_call(MODE_QUERY, n, $urandom_range(1, 2));
            end else begin
                case ($urandom_range(3))
                    0: send_item(MODE_UNUSED, 1'($urandom_range(1)),
                                 $urandom_range(0, COUNT_MAX),
                                 rand_sample(), rand_sample());
                    1: send_item(MODE_W'($urandom_range(0, 3)), 1'b0,
                                 $urandom_range(0, COUNT_MAX),
                                 rand_sample(), rand_sample());
                    2: send_call(MODE_PUSH, $urandom_range(CAPACITY + 1, COUNT_MAX), 1);
                    default: begin
                        n = $urandom_range(2, 16);
                        send_call($urandom_range(1) ? MODE_PUSH : MODE_CONSUME, n,
                                  $urandom_range(1, n - 1));
                    end
                endcase
            end
        end
    endtask

    task automatic test_random_traffic();
        write_threshold(0);
        random_calls(300, 1'b0);
        write_threshold(CAPACITY - 1);
        random_calls(100, 1'b0);
        write_threshold($urandom_range(1, 48));
        random_calls(300, 1'b0);
    endtask

    task automatic test_starved_at_max_threshold();
        write_threshold(CAPACITY);
        random_calls(200, 1'b0);
    endtask

    // Last stretch runs without any idling on either side
    task automatic test_steady_tail();
        write_threshold($urandom_range(0, 8));
        idle_pct = 0;
        random_calls(200, 1'b1);
    endtask

    // Stimulus sequence
    initial begin
        clear_buffer_model();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_cases();
        test_capacity_bounds();
        test_random_traffic();
        test_starved_at_max_threshold();
        test_steady_tail();
        i_in_valid <= 1'b0;
        while (expected_mix_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("Covered %0d push, %0d consume and %0d query elements, capacity edges,",
                 n_push, n_consume, n_query);
        $display("thresholds from 0 to %0d; %0d overflow and %0d underrun events seen.",
                 CAPACITY, ovf_cnt, udr_cnt);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### files.f
sv/ajfm_pkg.sv
sv/ajfm_ram.sv
sv/ajfm_ctrl.sv
sv/ajfm_mix.sv
sv/audio_jitter_fifo_mixer.sv
sv/ajfm_chk.sv
dv/audio_jitter_fifo_mixer_tb.sv
